/* rtl/lfr_pkg.sv */
// Shared types, constants and helpers of the line frame receive ring.
// Used by the front, back and top-level modules; depends on nothing else.
package lfr_pkg;

    localparam int SLOTS       = 6;
    localparam int SLOT_BYTES  = 64;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int POS_W       = $clog2(SLOT_BYTES);
    localparam int LEN_W       = $clog2(SLOT_BYTES + 1);
    localparam int STORE_DEPTH = SLOTS * SLOT_BYTES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W   = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_CHAR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN  = 2'd1;

    localparam logic [7:0] END_CHAR_RST = 8'd10;
    localparam logic [5:0] MIN_LEN_RST  = 6'd3;
    localparam logic [7:0] TERM_BYTE    = 8'd0;

    localparam logic OP_RECV = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_LINE   = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
        logic       is_end;
    } t_item;

    typedef struct packed {
        logic       strobe;
        logic [1:0] kind;
        logic [7:0] line_byte;
        logic       last_byte;
        logic       frame_done;
        logic       ring_full_warn;
        logic       overflow;
        logic       lines_pending;
    } t_result;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(SLOTS - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] s,
                                                    input logic [POS_W-1:0]  p);
        return ADDR_W'(s) * ADDR_W'(SLOT_BYTES) + ADDR_W'(p);
    endfunction

endpackage

/* rtl/line_frame_receive_ring_core.sv */
// Line frame receive ring: received bytes are split into lines kept in a ring of slots.
// Results are registered: a receive or an empty pop is reported from the idle state, closing a kept line
// passes through a terminator state, and a line pop streams its stored bytes from a pop state.
// The back end takes no new item until it is back in idle; line bytes come from the store read port.
// Reset: synchronous, active low; clears slot bookkeeping and queue, the store is not cleared.
// Depends on lfr_pkg, lfr_front, lfr_back and lfr_ram.
module line_frame_receive_ring_core
    import lfr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_opcode,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    output logic                 o_strobe,
    output logic [1:0]           o_kind,
    output logic [7:0]           o_line_byte,
    output logic                 o_last_byte,
    output logic                 o_frame_done,
    output logic                 o_ring_full_warn,
    output logic                 o_overflow,
    output logic                 o_lines_pending
);

    logic       item_valid;
    logic       take;
    t_item      item;
    logic [5:0] min_len;
    t_result    result;

    assign o_cfg_ready = 1'b1;

    lfr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_opcode     (i_opcode),
        .i_rx_byte    (i_rx_byte),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_take       (take),
        .o_item_valid (item_valid),
        .o_item       (item),
        .o_min_len    (min_len)
    );

    lfr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_take       (take),
        .i_min_len    (min_len),
        .o_result     (result)
    );

    assign o_strobe         = result.strobe;
    assign o_kind           = result.kind;
    assign o_line_byte      = result.line_byte;
    assign o_last_byte      = result.last_byte;
    assign o_frame_done     = result.frame_done;
    assign o_ring_full_warn = result.ring_full_warn;
    assign o_overflow       = result.overflow;
    assign o_lines_pending  = result.lines_pending;

    // A full-ring warning only comes with a completed line.
    a_warn_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_ring_full_warn |-> o_frame_done)
        else $error("ring full warning without completed line");

    // Only line results carry store data.
    a_line_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_kind != KIND_LINE) |-> (o_line_byte == 8'd0) && !o_last_byte)
        else $error("line data on a non-line result");

    // An empty pop means no line is waiting.
    a_empty_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_kind == KIND_EMPTY) |-> !o_lines_pending)
        else $error("empty report while lines pending");

    // The sequencer passes through idle after a line, so no line byte follows the last one.
    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last_byte |=> !(o_strobe && (o_kind == KIND_LINE)))
        else $error("line byte right after last byte");

endmodule

/* rtl/lfr_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package dependency.
module lfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/lfr_front.sv */
// Front end: configuration registers, end-character classification and the item queue.
// Depends on lfr_pkg.
module lfr_front
    import lfr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_opcode,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_take,
    output logic                 o_item_valid,
    output t_item                o_item,
    output logic [5:0]           o_min_len
);

    logic [7:0]        r_end_char;
    logic [5:0]        r_min_len;
    t_item             r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              push;
    t_item             new_item;

    assign busy         = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign push         = start && !busy;
    assign o_item_valid = (r_cnt != '0);
    assign o_item       = r_q[r_rp];
    assign o_min_len    = r_min_len;

    always_comb begin
        new_item.op     = i_opcode;
        new_item.data   = i_rx_byte;
        new_item.is_end = (i_rx_byte == r_end_char);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_char <= END_CHAR_RST;
            r_min_len  <= MIN_LEN_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_END_CHAR) begin
                r_end_char <= i_cfg_data;
            end else if (i_cfg_index == CFG_MIN_LEN) begin
                r_min_len <= i_cfg_data[5:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= new_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (i_take) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            if (push && !i_take) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (!push && i_take) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

/* rtl/lfr_back.sv */
// Back end: slot bookkeeping, line store and result sequencing.
// Depends on lfr_pkg and lfr_ram.
module lfr_back
    import lfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_item_valid,
    input  t_item      i_item,
    output logic       o_take,
    input  logic [5:0] i_min_len,
    output t_result    o_result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TERM = 2'd1;
    localparam logic [1:0] ST_POP  = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [SLOT_W-1:0] r_ws, n_ws;
    logic [SLOT_W-1:0] r_rs, n_rs;
    logic [POS_W-1:0]  r_wc, n_wc;
    logic [SLOTS-1:0]  r_valid, n_valid;
    logic [LEN_W-1:0]  r_len [SLOTS];
    logic [LEN_W-1:0]  n_len [SLOTS];
    logic [POS_W-1:0]  r_cnt, n_cnt;
    logic              r_ovf, n_ovf;
    logic [SLOT_W-1:0] r_pslot, n_pslot;
    logic [POS_W-1:0]  r_pidx, n_pidx;
    logic [LEN_W-1:0]  r_plen, n_plen;
    logic              r_after, n_after;

    logic              r_strobe, n_strobe;
    logic [1:0]        r_kind, n_kind;
    logic              r_last, n_last;
    logic              r_done, n_done;
    logic              r_warn, n_warn;
    logic              r_ovf_o, n_ovf_o;
    logic              r_pend, n_pend;
    logic              r_from_ram, n_from_ram;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic [7:0]        rdata;

    lfr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        logic              room;
        logic [POS_W-1:0]  cnt;
        logic [SLOT_W-1:0] nx;
        logic              last;

        n_state    = r_state;
        n_ws       = r_ws;
        n_rs       = r_rs;
        n_wc       = r_wc;
        n_valid    = r_valid;
        n_len      = r_len;
        n_cnt      = r_cnt;
        n_ovf      = r_ovf;
        n_pslot    = r_pslot;
        n_pidx     = r_pidx;
        n_plen     = r_plen;
        n_after    = r_after;
        n_strobe   = 1'b0;
        n_kind     = KIND_STATUS;
        n_last     = 1'b0;
        n_done     = 1'b0;
        n_warn     = 1'b0;
        n_ovf_o    = 1'b0;
        n_pend     = r_pend;
        n_from_ram = 1'b0;
        o_take     = 1'b0;
        we         = 1'b0;
        waddr      = slot_addr(r_ws, r_wc);
        wdata      = i_item.data;
        re         = 1'b0;
        raddr      = slot_addr(r_pslot, r_pidx);
        room       = (r_wc < POS_W'(SLOT_BYTES - 1));
        cnt        = room ? r_wc + POS_W'(1) : r_wc;
        nx         = next_slot(r_ws);
        last       = ((LEN_W'(r_pidx) + LEN_W'(1)) == r_plen);

        unique case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    o_take = 1'b1;
                    if (i_item.op == OP_RECV) begin
                        we = room;
                        if (i_item.is_end && (8'(cnt) > 8'(i_min_len))) begin
                            // Closing a kept line: terminator goes in on the next cycle.
                            n_cnt   = cnt;
                            n_ovf   = !room;
                            n_state = ST_TERM;
                        end else begin
                            n_wc     = i_item.is_end ? '0 : cnt;
                            n_strobe = 1'b1;
                            n_ovf_o  = !room;
                            n_pend   = r_valid[r_rs];
                        end
                    end else if (!r_valid[r_rs]) begin
                        n_strobe = 1'b1;
                        n_kind   = KIND_EMPTY;
                        n_pend   = 1'b0;
                    end else begin
                        n_pslot          = r_rs;
                        n_pidx           = '0;
                        n_plen           = r_len[r_rs];
                        n_valid[r_rs]    = 1'b0;
                        n_rs             = next_slot(r_rs);
                        n_after          = r_valid[next_slot(r_rs)];
                        n_state          = ST_POP;
                    end
                end
            end
            ST_TERM: begin
                we            = 1'b1;
                waddr         = slot_addr(r_ws, r_cnt);
                wdata         = TERM_BYTE;
                n_len[r_ws]   = LEN_W'(r_cnt) + LEN_W'(1);
                n_valid[r_ws] = 1'b1;
                n_warn        = r_valid[nx];
                if (!r_valid[nx]) begin
                    n_ws = nx;
                end
                n_wc     = '0;
                n_strobe = 1'b1;
                n_done   = 1'b1;
                n_ovf_o  = r_ovf;
                n_pend   = (r_rs == r_ws) ? 1'b1 : r_valid[r_rs];
                n_state  = ST_IDLE;
            end
            ST_POP: begin
                re         = 1'b1;
                n_strobe   = 1'b1;
                n_kind     = KIND_LINE;
                n_from_ram = 1'b1;
                n_pend     = r_after;
                n_last     = last;
                n_pidx     = r_pidx + POS_W'(1);
                if (last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ws     <= '0;
            r_rs     <= '0;
            r_wc     <= '0;
            r_valid  <= '0;
            r_strobe <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ws     <= n_ws;
            r_rs     <= n_rs;
            r_wc     <= n_wc;
            r_valid  <= n_valid;
            r_strobe <= n_strobe;
            r_pend   <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len      <= n_len;
        r_cnt      <= n_cnt;
        r_ovf      <= n_ovf;
        r_pslot    <= n_pslot;
        r_pidx     <= n_pidx;
        r_plen     <= n_plen;
        r_after    <= n_after;
        r_kind     <= n_kind;
        r_last     <= n_last;
        r_done     <= n_done;
        r_warn     <= n_warn;
        r_ovf_o    <= n_ovf_o;
        r_from_ram <= n_from_ram;
    end

    always_comb begin
        o_result.strobe         = r_strobe;
        o_result.kind           = r_kind;
        o_result.line_byte      = r_from_ram ? rdata : 8'd0;
        o_result.last_byte      = r_last;
        o_result.frame_done     = r_done;
        o_result.ring_full_warn = r_warn;
        o_result.overflow       = r_ovf_o;
        o_result.lines_pending  = r_pend;
    end

endmodule
